// ===== rtl/core/es2cal_pkg.sv =====
// Constants and helpers for the epoch-seconds to calendar date converter.
package es2cal_pkg;

	// Field widths
	localparam int unsigned EpochW = 31;
	localparam int unsigned YearW  = 11;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned HourW  = 5;
	localparam int unsigned MinW   = 6;
	localparam int unsigned SecW   = 6;

	// Internal widths
	localparam int unsigned DaysW  = 15;  // whole days since the epoch, up to 24855
	localparam int unsigned SodW   = 17;  // seconds of the day, below 86400
	localparam int unsigned TminW  = 11;  // minutes of the day, below 1440
	localparam int unsigned CycW   = 5;   // four-year cycles since 1968
	localparam int unsigned CycRW  = 11;  // day within a four-year cycle, below 1461
	localparam int unsigned DoyW   = 9;   // day of the year from 0

	// Seconds per day is 128 * 675: shift off seven bits, then divide by 675
	localparam logic [24:0] RecipDay   = 25'd25451659;  // ceil(2^34 / 675)
	localparam int unsigned RecipDayK  = 34;
	localparam logic [9:0]  DayOdd     = 10'd675;

	// Divide by 60 as a shift by two and a divide by 15
	localparam logic [15:0] RecipMinSec = 16'd34953;    // ceil(2^19 / 15)
	localparam int unsigned RecipMinK   = 19;
	localparam logic [9:0]  RecipHour   = 10'd547;      // ceil(2^13 / 15)
	localparam int unsigned RecipHourK  = 13;
	localparam logic [5:0]  SixtyC      = 6'd60;

	// Four-year cycles counted from 1968, a leap year
	localparam logic [15:0] RecipCyc    = 16'd45934;    // ceil(2^26 / 1461)
	localparam int unsigned RecipCycK   = 26;
	localparam logic [10:0] CycDays     = 11'd1461;
	localparam logic [9:0]  EpochOffset = 10'd731;      // days from 1968-01-01 to 1970-01-01
	localparam logic [YearW-1:0] CycBaseYear = 11'd1968;

	// Year boundaries within a four-year cycle: leap year first
	localparam logic [CycRW-1:0] Yb1 = 11'd366;
	localparam logic [CycRW-1:0] Yb2 = 11'd731;
	localparam logic [CycRW-1:0] Yb3 = 11'd1096;

	localparam logic [MonthW-1:0] MonthJan = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;

	// Day of the year (from 0) on which a month starts
	function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DoyW-1:0] base;
		unique case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		// Leap day pushes every month after February back by one
		if (leap && (m > MonthFeb))
			base = base + 9'd1;
		return base;
	endfunction

endpackage

// ===== rtl/core/epoch_seconds_to_calendar_top.sv =====
// Pipelined conversion of seconds since 1970 into date and time of day.
// Six register stages lie between the input accept and output valid.
// Throughput: one item per cycle unless the output is held; set by the six-stage
// pipeline of constant reciprocal multiplies, each registered before its correction step.
// The whole pipeline holds while the output item waits to be taken.
// Reset clears all stage valid bits; data registers are not reset.
module epoch_seconds_to_calendar_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [es2cal_pkg::EpochW-1:0] epoch_seconds,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [es2cal_pkg::YearW-1:0]  year,
	output logic [es2cal_pkg::MonthW-1:0] month,
	output logic [es2cal_pkg::DayW-1:0]   day_of_month,
	output logic [es2cal_pkg::HourW-1:0]  hour,
	output logic [es2cal_pkg::MinW-1:0]   minute,
	output logic [es2cal_pkg::SecW-1:0]   second
);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// Stage 1 registers
	logic [es2cal_pkg::EpochW-1:0] t_s1;
	logic [48:0]                   pday_s1;
	// Stage 2 registers
	logic [es2cal_pkg::DaysW-1:0]  days_s2;
	logic [es2cal_pkg::SodW-1:0]   sod_s2;
	// Stage 3 registers
	logic [es2cal_pkg::DaysW-1:0]  dp_s3;
	logic [30:0]                   pcyc_s3;
	logic [es2cal_pkg::SodW-1:0]   sod_s3;
	logic [30:0]                   pmin_s3;
	// Stage 4 registers
	logic [es2cal_pkg::CycW-1:0]   cyc_s4;
	logic [es2cal_pkg::CycRW-1:0]  cycr_s4;
	logic [es2cal_pkg::TminW-1:0]  tmin_s4;
	logic [es2cal_pkg::SecW-1:0]   sec_s4;
	// Stage 5 registers
	logic [es2cal_pkg::YearW-1:0]  year_s5;
	logic [es2cal_pkg::DoyW-1:0]   doy_s5;
	logic                          leap_s5;
	logic [18:0]                   phr_s5;
	logic [es2cal_pkg::TminW-1:0]  tmin_s5;
	logic [es2cal_pkg::SecW-1:0]   sec_s5;
	// Stage 6 registers, the output stage
	logic [es2cal_pkg::YearW-1:0]  year_s6;
	logic [es2cal_pkg::MonthW-1:0] month_s6;
	logic [es2cal_pkg::DayW-1:0]   day_s6;
	logic [es2cal_pkg::HourW-1:0]  hour_s6;
	logic [es2cal_pkg::MinW-1:0]   min_s6;
	logic [es2cal_pkg::SecW-1:0]   sec_s6;

	// Combinational values between stages
	logic [es2cal_pkg::DaysW-1:0]  days_c;
	logic [24:0]                   dayprod_c;
	logic [9:0]                    dayrem_c;
	logic [es2cal_pkg::DaysW-1:0]  dp_c;
	logic [es2cal_pkg::CycW-1:0]   cyc_c;
	logic [es2cal_pkg::CycRW-1:0]  cycr_c;
	logic [es2cal_pkg::TminW-1:0]  tmin_c;
	logic [es2cal_pkg::SodW-1:0]   sec_full_c;
	logic [1:0]                    yic_c;
	logic [es2cal_pkg::DoyW-1:0]   doy_c;
	logic [es2cal_pkg::YearW-1:0]  year_c;
	logic [es2cal_pkg::HourW-1:0]  hour_c;
	logic [es2cal_pkg::TminW-1:0]  minfull_c;
	logic [es2cal_pkg::MonthW-1:0] month_c;
	logic [es2cal_pkg::DoyW-1:0]   mbase_c;
	logic [es2cal_pkg::DoyW-1:0]   mday_c;

	// Advance every stage unless the output item is held
	assign adv      = ~vld_s6 | out_ready;
	assign in_ready = adv;

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 2 logic: whole days and the remainder in seconds
	always_comb begin
		days_c     = pday_s1[48:es2cal_pkg::RecipDayK];
		dayprod_c  = 25'(days_c) * 25'(es2cal_pkg::DayOdd);
		dayrem_c   = 10'(25'(t_s1[30:7]) - dayprod_c);
	end

	// Stage 3 logic: shift the day count so that it counts from 1968-01-01
	assign dp_c = days_s2 + es2cal_pkg::DaysW'(es2cal_pkg::EpochOffset);

	// Stage 4 logic: cycle and day in cycle, minutes of day and seconds
	always_comb begin
		cyc_c      = pcyc_s3[30:es2cal_pkg::RecipCycK];
		cycr_c     = es2cal_pkg::CycRW'(dp_s3 - es2cal_pkg::DaysW'(
			16'(cyc_c) * 16'(es2cal_pkg::CycDays)));
		tmin_c     = pmin_s3[29:es2cal_pkg::RecipMinK];
		sec_full_c = sod_s3 - es2cal_pkg::SodW'(17'(tmin_c) * 17'(es2cal_pkg::SixtyC));
	end

	// Stage 5 logic: year within the cycle and day of the year
	always_comb begin
		if (cycr_s4 < es2cal_pkg::Yb1) begin
			yic_c = 2'd0;
			doy_c = es2cal_pkg::DoyW'(cycr_s4);
		end else if (cycr_s4 < es2cal_pkg::Yb2) begin
			yic_c = 2'd1;
			doy_c = es2cal_pkg::DoyW'(cycr_s4 - es2cal_pkg::Yb1);
		end else if (cycr_s4 < es2cal_pkg::Yb3) begin
			yic_c = 2'd2;
			doy_c = es2cal_pkg::DoyW'(cycr_s4 - es2cal_pkg::Yb2);
		end else begin
			yic_c = 2'd3;
			doy_c = es2cal_pkg::DoyW'(cycr_s4 - es2cal_pkg::Yb3);
		end
		year_c = es2cal_pkg::CycBaseYear + es2cal_pkg::YearW'({cyc_s4, 2'b00})
			+ es2cal_pkg::YearW'(yic_c);
	end

	// Stage 6 logic: hour and minute, then month and day of month
	always_comb begin
		hour_c    = phr_s5[17:es2cal_pkg::RecipHourK];
		minfull_c = tmin_s5 - es2cal_pkg::TminW'(11'(hour_c) * 11'(es2cal_pkg::SixtyC));
		month_c   = es2cal_pkg::MonthJan;
		mbase_c   = '0;
		// Months start in rising order, so the last match wins
		for (int m = 2; m <= 12; m++) begin
			if (doy_s5 >= es2cal_pkg::month_start(es2cal_pkg::MonthW'(m), leap_s5)) begin
				month_c = es2cal_pkg::MonthW'(m);
				mbase_c = es2cal_pkg::month_start(es2cal_pkg::MonthW'(m), leap_s5);
			end
		end
		mday_c = doy_s5 - mbase_c + es2cal_pkg::DoyW'(1);
	end

	// Pipeline data registers
	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: days as a reciprocal product of the seconds over 128
			t_s1    <= epoch_seconds;
			pday_s1 <= 49'(epoch_seconds[30:7]) * 49'(es2cal_pkg::RecipDay);
			// Stage 2
			days_s2 <= days_c;
			sod_s2  <= {dayrem_c, t_s1[6:0]};
			// Stage 3: reciprocal products for cycles and minutes
			dp_s3   <= dp_c;
			pcyc_s3 <= 31'(dp_c) * 31'(es2cal_pkg::RecipCyc);
			sod_s3  <= sod_s2;
			pmin_s3 <= 31'(sod_s2[16:2]) * 31'(es2cal_pkg::RecipMinSec);
			// Stage 4
			cyc_s4  <= cyc_c;
			cycr_s4 <= cycr_c;
			tmin_s4 <= tmin_c;
			sec_s4  <= es2cal_pkg::SecW'(sec_full_c);
			// Stage 5: reciprocal product for hours
			year_s5 <= year_c;
			doy_s5  <= doy_c;
			leap_s5 <= (yic_c == 2'd0);
			phr_s5  <= 19'(tmin_s4[10:2]) * 19'(es2cal_pkg::RecipHour);
			tmin_s5 <= tmin_s4;
			sec_s5  <= sec_s4;
			// Stage 6
			year_s6  <= year_s5;
			month_s6 <= month_c;
			day_s6   <= es2cal_pkg::DayW'(mday_c);
			hour_s6  <= hour_c;
			min_s6   <= es2cal_pkg::MinW'(minfull_c);
			sec_s6   <= sec_s5;
		end
	end

	assign out_valid    = vld_s6;
	assign year         = year_s6;
	assign month        = month_s6;
	assign day_of_month = day_s6;
	assign hour         = hour_s6;
	assign minute       = min_s6;
	assign second       = sec_s6;

	// Month stays in calendar range and day of month is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= es2cal_pkg::MonthJan) && (month <= es2cal_pkg::MonthDec)
			&& (day_of_month != '0))
		else $error("month or day out of range");

	// Time of day fields stay in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
		else $error("time of day out of range");

	// February has no 29th outside leap years
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (month == es2cal_pkg::MonthFeb) && (year[1:0] != 2'b00))
			|-> (day_of_month <= 5'd28))
		else $error("leap day in a common year");

	// An item held at the output keeps the input side stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while output stalled");

endmodule
